// ===== hw/rtl/dirty_tile_map_with_run_rects_top_macros.svh =====
// ----------------------------------------------------------------------------
// Dirty tile map assertion macros
// Shared concurrent assertion forms, clocked on clk and held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef DIRTY_TILE_MAP_WITH_RUN_RECTS_TOP_MACROS_SVH
`define DIRTY_TILE_MAP_WITH_RUN_RECTS_TOP_MACROS_SVH

// The condition implies the property in the same cycle.
`define DTM_ASSERT_NOW(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The condition implies the property in the following cycle.
`define DTM_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/dtm_pkg.sv =====
// ----------------------------------------------------------------------------
// Dirty tile map package
// Grid sizes, field widths, command and register codes, and shared types.
// ----------------------------------------------------------------------------
package dtm_pkg;

    localparam int GRID_COLS = 16;
    localparam int GRID_ROWS = 8;

    localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int SPAN_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CNT_W  = (GRID_COLS > GRID_ROWS) ? $clog2(GRID_COLS + 1)
                                                    : $clog2(GRID_ROWS + 1);

    localparam int CMD_W      = 2;
    localparam int XW         = 11;
    localparam int YW         = 10;
    localparam int AW         = 12;
    localparam int TS_W       = 3;
    localparam int PW_W       = 12;
    localparam int PH_W       = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_DIRTY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_SHIFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_HEIGHT = 2'd2;

    localparam logic [TS_W-1:0] TILE_SHIFT_RST   = 3'd3;
    localparam logic [PW_W-1:0] PIXEL_WIDTH_RST  = 12'd128;
    localparam logic [PH_W-1:0] PIXEL_HEIGHT_RST = 11'd64;

    typedef enum logic [1:0] {
        OP_DIRTY,
        OP_CLEAN,
        OP_SCAN
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic [TS_W-1:0] tile_shift;
        logic [PW_W-1:0] pixel_width;
        logic [PH_W-1:0] pixel_height;
    } cfg_t;

    typedef struct packed {
        op_t              op;
        logic             empty;
        logic [COL_W-1:0] col_lo;
        logic [COL_W-1:0] col_hi;
        logic [ROW_W-1:0] row_lo;
        logic [ROW_W-1:0] row_hi;
        logic [TS_W-1:0]  tile_shift;
        logic [XW-1:0]    x_first;
        logic [XW-1:0]    x_last;
        logic [YW-1:0]    y_first;
        logic [YW-1:0]    y_last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic [XW-1:0] x_first;
        logic [XW-1:0] x_last;
        logic [YW-1:0] y_first;
        logic [YW-1:0] y_last;
    } rect_t;

endpackage

// ===== hw/rtl/dtm_ifs.sv =====
// ----------------------------------------------------------------------------
// Dirty tile map channels
// Command, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface dtm_req_if;
    import dtm_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [XW-1:0]    x_first;
    logic [XW-1:0]    x_last;
    logic [YW-1:0]    y_first;
    logic [YW-1:0]    y_last;

    modport source (output valid, cmd, x_first, x_last, y_first, y_last, input ready);
    modport sink (input valid, cmd, x_first, x_last, y_first, y_last, output ready);
endinterface

interface dtm_rsp_if;
    import dtm_pkg::*;

    logic          valid;
    logic          ready;
    logic          rect_valid;
    logic          last;
    logic [XW-1:0] out_x_first;
    logic [XW-1:0] out_x_last;
    logic [YW-1:0] out_y_first;
    logic [YW-1:0] out_y_last;

    modport source (output valid, rect_valid, last, out_x_first, out_x_last,
                    out_y_first, out_y_last, input ready);
    modport sink (input valid, rect_valid, last, out_x_first, out_x_last,
                  out_y_first, out_y_last, output ready);
endinterface

interface dtm_cfg_if;
    import dtm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink (input valid, idx, data, output ready);
endinterface

// ===== hw/rtl/dirty_tile_map_with_run_rects_top.sv =====
// ----------------------------------------------------------------------------
// Dirty tile map with run rectangles
// Dirty and clean write their R tile rows in turn after accept, and a scan
// with N runs holds the back end while it walks the rows and emits the runs.
// Each run is held until the next one is found so the final beat can be flagged.
// Reset clears the queue and output valid, sets every dirty bit, loads default regs.
// ----------------------------------------------------------------------------
`include "dirty_tile_map_with_run_rects_top_macros.svh"

module dirty_tile_map_with_run_rects_top (
    input  logic      clk,
    input  logic      rst_n,
    dtm_cfg_if.sink   cfg,
    dtm_req_if.sink   req,
    dtm_rsp_if.source rsp
);
    import dtm_pkg::*;

    logic [TS_W-1:0] tile_shift_reg;
    logic [TS_W-1:0] tile_shift_next;
    logic [PW_W-1:0] pixel_width_reg;
    logic [PW_W-1:0] pixel_width_next;
    logic [PH_W-1:0] pixel_height_reg;
    logic [PH_W-1:0] pixel_height_next;
    logic            cfg_wr;
    logic            set_all;
    cfg_t            cfg_cur;
    logic            push;
    logic            pop;
    job_t            job_in;
    job_t            head;
    queue_stat_t     q_stat;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign set_all   = cfg_wr && ((cfg.idx == REG_PIXEL_WIDTH) ||
                                  (cfg.idx == REG_PIXEL_HEIGHT));

    always_comb
    begin
        tile_shift_next   = tile_shift_reg;
        pixel_width_next  = pixel_width_reg;
        pixel_height_next = pixel_height_reg;
        if (cfg_wr)
        begin
            unique case (cfg.idx)
                REG_TILE_SHIFT:   tile_shift_next   = cfg.data[TS_W-1:0];
                REG_PIXEL_WIDTH:  pixel_width_next  = cfg.data[PW_W-1:0];
                REG_PIXEL_HEIGHT: pixel_height_next = cfg.data[PH_W-1:0];
                default:          tile_shift_next   = tile_shift_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_shift_reg   <= TILE_SHIFT_RST;
            pixel_width_reg  <= PIXEL_WIDTH_RST;
            pixel_height_reg <= PIXEL_HEIGHT_RST;
        end
        else
        begin
            tile_shift_reg   <= tile_shift_next;
            pixel_width_reg  <= pixel_width_next;
            pixel_height_reg <= pixel_height_next;
        end
    end

    assign cfg_cur.tile_shift   = tile_shift_reg;
    assign cfg_cur.pixel_width  = pixel_width_reg;
    assign cfg_cur.pixel_height = pixel_height_reg;

    dtm_front u_front (
        .req    (req),
        .cfg    (cfg_cur),
        .q_full (q_stat.full),
        .push   (push),
        .job    (job_in)
    );

    dtm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .job_in (job_in),
        .pop    (pop),
        .head   (head),
        .stat   (q_stat)
    );

    dtm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .set_all (set_all),
        .head    (head),
        .q_stat  (q_stat),
        .pop     (pop),
        .rsp     (rsp)
    );

    `DTM_ASSERT_NOW(a_push_not_full, push, !q_stat.full, "job pushed into a full queue")
    `DTM_ASSERT_NOW(a_pop_not_empty, pop, !q_stat.empty, "job popped from an empty queue")
    `DTM_ASSERT_NEXT(a_push_kept, push && q_stat.empty, !q_stat.empty, "queue lost a job")

endmodule

// ===== hw/rtl/dtm_front.sv =====
// ----------------------------------------------------------------------------
// Dirty tile map front end
// Decodes a command and turns its pixel rectangle into a clipped tile span.
// ----------------------------------------------------------------------------
module dtm_front (
    dtm_req_if.sink         req,
    input  dtm_pkg::cfg_t   cfg,
    input  logic            q_full,
    output logic            push,
    output dtm_pkg::job_t   job
);
    import dtm_pkg::*;

    typedef struct packed {
        logic              empty;
        logic [SPAN_W-1:0] lo;
        logic [SPAN_W-1:0] hi;
    } span_t;

    function automatic span_t clip_span(input logic [AW-1:0] lo_t, input logic hi_neg,
                                        input logic [AW-1:0] hi_t,
                                        input logic [CNT_W-1:0] n);
        span_t          s;
        logic [AW-1:0]  n_m1;
        logic [AW-1:0]  hi_c;
        n_m1    = AW'(n) - AW'(1);
        hi_c    = (hi_t > n_m1) ? n_m1 : hi_t;
        s.empty = hi_neg || (n == '0) || (lo_t > hi_c);
        s.lo    = lo_t[SPAN_W-1:0];
        s.hi    = hi_c[SPAN_W-1:0];
        return s;
    endfunction

    logic [TS_W-1:0]  ts;
    logic [AW-1:0]    rnd;
    logic [PW_W:0]    col_sum;
    logic [PW_W:0]    col_quot;
    logic [PH_W:0]    row_sum;
    logic [PH_W:0]    row_quot;
    logic [CNT_W-1:0] cols;
    logic [CNT_W-1:0] rows;
    logic             clean;
    logic             inverted;
    logic [AW-1:0]    x_lo_px;
    logic [AW-1:0]    y_lo_px;
    logic [AW-1:0]    xl_w;
    logic [AW-1:0]    yl_w;
    logic [AW-1:0]    pw_w;
    logic [AW-1:0]    ph_w;
    logic             x_border;
    logic             y_border;
    logic             x_hi_neg;
    logic             y_hi_neg;
    logic [AW-1:0]    x_hi_t;
    logic [AW-1:0]    y_hi_t;
    span_t            x_span;
    span_t            y_span;
    logic             keep;
    op_t              op;

    always_comb
    begin
        ts       = cfg.tile_shift;
        rnd      = (AW'(1) << ts) - AW'(1);
        col_sum  = {1'b0, cfg.pixel_width} + (PW_W + 1)'(rnd);
        col_quot = col_sum >> ts;
        cols     = (col_quot > (PW_W + 1)'(GRID_COLS)) ? CNT_W'(GRID_COLS)
                                                       : col_quot[CNT_W-1:0];
        row_sum  = {1'b0, cfg.pixel_height} + (PH_W + 1)'(rnd);
        row_quot = row_sum >> ts;
        rows     = (row_quot > (PH_W + 1)'(GRID_ROWS)) ? CNT_W'(GRID_ROWS)
                                                       : row_quot[CNT_W-1:0];

        clean    = (req.cmd == CMD_CLEAN);
        inverted = (req.x_first > req.x_last) || (req.y_first > req.y_last);
        xl_w     = AW'(req.x_last);
        yl_w     = AW'(req.y_last);
        pw_w     = AW'(cfg.pixel_width);
        ph_w     = AW'(cfg.pixel_height);

        x_lo_px  = clean ? AW'(req.x_first) + rnd : AW'(req.x_first);
        y_lo_px  = clean ? AW'(req.y_first) + rnd : AW'(req.y_first);
        x_border = (xl_w + AW'(1)) >= pw_w;
        y_border = (yl_w + AW'(1)) >= ph_w;
        x_hi_neg = clean && !x_border && (xl_w < rnd);
        y_hi_neg = clean && !y_border && (yl_w < rnd);

        if (!clean)
        begin
            x_hi_t = xl_w >> ts;
            y_hi_t = yl_w >> ts;
        end
        else
        begin
            x_hi_t = x_border ? (pw_w >> ts) : ((xl_w - rnd) >> ts);
            y_hi_t = y_border ? (ph_w >> ts) : ((yl_w - rnd) >> ts);
        end

        x_span = clip_span(x_lo_px >> ts, x_hi_neg, x_hi_t, cols);
        y_span = clip_span(y_lo_px >> ts, y_hi_neg, y_hi_t, rows);
    end

    always_comb
    begin
        op   = OP_SCAN;
        keep = 1'b0;
        unique case (req.cmd)
            CMD_DIRTY:
            begin
                op   = OP_DIRTY;
                keep = !inverted && !x_span.empty && !y_span.empty;
            end
            CMD_CLEAN:
            begin
                op   = OP_CLEAN;
                keep = !inverted && !x_span.empty && !y_span.empty;
            end
            CMD_SCAN:
            begin
                op   = OP_SCAN;
                keep = 1'b1;
            end
            default:
            begin
                op   = OP_SCAN;
                keep = 1'b0;
            end
        endcase
    end

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full && keep;

    always_comb
    begin
        job.op         = op;
        job.empty      = inverted || x_span.empty || y_span.empty;
        job.col_lo     = x_span.lo[COL_W-1:0];
        job.col_hi     = x_span.hi[COL_W-1:0];
        job.row_lo     = y_span.lo[ROW_W-1:0];
        job.row_hi     = y_span.hi[ROW_W-1:0];
        job.tile_shift = cfg.tile_shift;
        job.x_first    = req.x_first;
        job.x_last     = req.x_last;
        job.y_first    = req.y_first;
        job.y_last     = req.y_last;
    end

endmodule

// ===== hw/rtl/dtm_queue.sv =====
// ----------------------------------------------------------------------------
// Dirty tile map job queue
// Short first-in first-out buffer of decoded jobs between front and back.
// ----------------------------------------------------------------------------
module dtm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dtm_pkg::job_t        job_in,
    input  logic                 pop,
    output dtm_pkg::job_t        head,
    output dtm_pkg::queue_stat_t stat
);
    import dtm_pkg::*;

    job_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ===== hw/rtl/dtm_back.sv =====
// ----------------------------------------------------------------------------
// Dirty tile map back end
// Holds the dirty bitmap, fills tile rows and walks rows to emit dirty runs.
// ----------------------------------------------------------------------------
module dtm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 set_all,
    input  dtm_pkg::job_t        head,
    input  dtm_pkg::queue_stat_t q_stat,
    output logic                 pop,
    dtm_rsp_if.source            rsp
);
    import dtm_pkg::*;

    function automatic logic [CNT_W-1:0] lowest_one(input logic [GRID_COLS:0] v);
        logic [CNT_W-1:0] r;
        r = '0;
        for (int i = GRID_COLS; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = CNT_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [GRID_COLS-1:0] span_mask(input logic [COL_W-1:0] lo,
                                                       input logic [COL_W-1:0] hi);
        logic [GRID_COLS-1:0] m;
        for (int i = 0; i < GRID_COLS; i++)
        begin
            m[i] = (COL_W'(i) >= lo) && (COL_W'(i) <= hi);
        end
        return m;
    endfunction

    back_state_t          state_reg;
    back_state_t          state_next;
    job_t                 job_reg;
    job_t                 job_next;
    logic [GRID_COLS-1:0] mask_reg;
    logic [GRID_COLS-1:0] mask_next;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;
    logic [GRID_COLS-1:0] rem_reg;
    logic [GRID_COLS-1:0] rem_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    rect_t                pend_reg;
    rect_t                pend_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_rect_valid_reg;
    logic                 out_rect_valid_next;
    logic                 out_last_reg;
    logic                 out_last_next;
    rect_t                out_rect_reg;
    rect_t                out_rect_next;
    logic [GRID_COLS-1:0] bitmap_reg [GRID_ROWS];
    logic [GRID_COLS-1:0] bitmap_next [GRID_ROWS];

    logic                 out_free;
    logic                 row_at_end;
    logic                 run_take;
    logic                 row_step;
    logic                 fill_en;
    logic                 emit_mid;
    logic                 emit_final;
    logic [ROW_W-1:0]     rd_addr;
    logic [GRID_COLS-1:0] rd_row;
    logic [GRID_COLS-1:0] head_mask;
    logic [GRID_COLS-1:0] run_lsb;
    logic [GRID_COLS:0]   run_sum;
    logic [CNT_W-1:0]     run_start;
    logic [CNT_W-1:0]     run_end;
    logic [AW-1:0]        ra;
    logic [AW-1:0]        rb;
    logic [AW-1:0]        rc;
    logic [AW-1:0]        rd;
    rect_t                run_rect;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign row_at_end = (row_reg == job_reg.row_hi);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    if (head.op != OP_SCAN)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (head.empty)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FILL:
            begin
                if (row_at_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if ((rem_reg == '0) && row_at_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        fill_en    = 1'b0;
        run_take   = 1'b0;
        row_step   = 1'b0;
        emit_mid   = 1'b0;
        emit_final = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop = !q_stat.empty;
            end
            ST_FILL:
            begin
                fill_en = 1'b1;
            end
            ST_SCAN:
            begin
                run_take = (rem_reg != '0) && (!pend_valid_reg || out_free);
                emit_mid = (rem_reg != '0) && pend_valid_reg && out_free;
                row_step = (rem_reg == '0) && !row_at_end;
            end
            ST_DONE:
            begin
                emit_final = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rd_addr   = (state_reg == ST_IDLE) ? head.row_lo : row_reg + ROW_W'(1);
        rd_row    = bitmap_reg[rd_addr];
        head_mask = span_mask(head.col_lo, head.col_hi);

        run_lsb   = rem_reg & (~rem_reg + GRID_COLS'(1));
        run_sum   = {1'b0, rem_reg} + {1'b0, run_lsb};
        run_start = lowest_one({1'b0, rem_reg});
        run_end   = lowest_one(run_sum);

        ra = AW'(run_start) << job_reg.tile_shift;
        rb = (AW'(run_end) << job_reg.tile_shift) - AW'(1);
        rc = AW'(row_reg) << job_reg.tile_shift;
        rd = ((AW'(row_reg) + AW'(1)) << job_reg.tile_shift) - AW'(1);
        if (ra < AW'(job_reg.x_first))
        begin
            ra = AW'(job_reg.x_first);
        end
        if (rb > AW'(job_reg.x_last))
        begin
            rb = AW'(job_reg.x_last);
        end
        if (rc < AW'(job_reg.y_first))
        begin
            rc = AW'(job_reg.y_first);
        end
        if (rd > AW'(job_reg.y_last))
        begin
            rd = AW'(job_reg.y_last);
        end
        run_rect.x_first = ra[XW-1:0];
        run_rect.x_last  = rb[XW-1:0];
        run_rect.y_first = rc[YW-1:0];
        run_rect.y_last  = rd[YW-1:0];
    end

    always_comb
    begin
        job_next            = job_reg;
        mask_next           = mask_reg;
        row_next            = row_reg;
        rem_next            = rem_reg;
        pend_valid_next     = pend_valid_reg;
        pend_next           = pend_reg;
        out_valid_next      = out_valid_reg && !rsp.ready;
        out_rect_valid_next = out_rect_valid_reg;
        out_last_next       = out_last_reg;
        out_rect_next       = out_rect_reg;

        if (pop)
        begin
            job_next  = head;
            mask_next = head_mask;
            row_next  = head.row_lo;
            rem_next  = rd_row & head_mask;
        end
        if (fill_en && !row_at_end)
        begin
            row_next = row_reg + ROW_W'(1);
        end
        if (row_step)
        begin
            row_next = row_reg + ROW_W'(1);
            rem_next = rd_row & mask_reg;
        end
        if (run_take)
        begin
            rem_next        = rem_reg & run_sum[GRID_COLS-1:0];
            pend_valid_next = 1'b1;
            pend_next       = run_rect;
        end
        if (emit_mid)
        begin
            out_valid_next      = 1'b1;
            out_rect_valid_next = 1'b1;
            out_last_next       = 1'b0;
            out_rect_next       = pend_reg;
        end
        if (emit_final)
        begin
            out_valid_next      = 1'b1;
            out_rect_valid_next = pend_valid_reg;
            out_last_next       = 1'b1;
            out_rect_next       = pend_valid_reg ? pend_reg : '0;
            pend_valid_next     = 1'b0;
        end

        for (int r = 0; r < GRID_ROWS; r++)
        begin
            bitmap_next[r] = bitmap_reg[r];
            if (set_all)
            begin
                bitmap_next[r] = '1;
            end
            else if (fill_en && (row_reg == ROW_W'(r)))
            begin
                if (job_reg.op == OP_DIRTY)
                begin
                    bitmap_next[r] = bitmap_reg[r] | mask_reg;
                end
                else
                begin
                    bitmap_next[r] = bitmap_reg[r] & ~mask_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int r = 0; r < GRID_ROWS; r++)
            begin
                bitmap_reg[r] <= '1;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            for (int r = 0; r < GRID_ROWS; r++)
            begin
                bitmap_reg[r] <= bitmap_next[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg            <= job_next;
        mask_reg           <= mask_next;
        row_reg            <= row_next;
        rem_reg            <= rem_next;
        pend_reg           <= pend_next;
        out_rect_valid_reg <= out_rect_valid_next;
        out_last_reg       <= out_last_next;
        out_rect_reg       <= out_rect_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.rect_valid  = out_rect_valid_reg;
    assign rsp.last        = out_last_reg;
    assign rsp.out_x_first = out_rect_reg.x_first;
    assign rsp.out_x_last  = out_rect_reg.x_last;
    assign rsp.out_y_first = out_rect_reg.y_first;
    assign rsp.out_y_last  = out_rect_reg.y_last;

endmodule

// ===== tb/tb_dirty_tile_map_with_run_rects_top.sv =====
// ----------------------------------------------------------------------------
// Dirty tile map with run rectangles testbench
// Drives mark dirty, clean and scan commands through the request channel and
// rewrites the grid registers between phases while the block is idle. A
// scoreboard keeps its own copy of the tile bitmap, predicts every rectangle
// beat of each scan, and compares the response beats in order. Both sides
// idle at random, with some phases running at full rate.
// ----------------------------------------------------------------------------
module tb_dirty_tile_map_with_run_rects_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dtm_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_NONE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int ITEM_TARGET   = 350;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1500000;

    typedef struct packed {
        logic          rect_valid;
        logic          last;
        logic [XW-1:0] x_first;
        logic [XW-1:0] x_last;
        logic [YW-1:0] y_first;
        logic [YW-1:0] y_last;
    } run_rect_t;

    class run_rect_board;
        int unsigned           errors;
        int                    shift;
        int                    width;
        int                    height;
        logic [GRID_COLS-1:0]  dirty_rows [GRID_ROWS];
        run_rect_t             pending_rects [$];

        function void reset_state();
            errors = 0;
            shift  = int'(TILE_SHIFT_RST);
            width  = int'(PIXEL_WIDTH_RST);
            height = int'(PIXEL_HEIGHT_RST);
            foreach (dirty_rows[i])
                dirty_rows[i] = '1;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TILE_SHIFT:
                    shift = int'(data[TS_W-1:0]);
                REG_PIXEL_WIDTH:
                begin
                    width = int'(data[PW_W-1:0]);
                    foreach (dirty_rows[i])
                        dirty_rows[i] = '1;
                end
                REG_PIXEL_HEIGHT:
                begin
                    height = int'(data[PH_W-1:0]);
                    foreach (dirty_rows[i])
                        dirty_rows[i] = '1;
                end
                default:
                    ;
            endcase
        endfunction

        function int tiles_in(int pixels, int limit);
            int n;
            n = (pixels + (1 << shift) - 1) >>> shift;
            return (n > limit) ? limit : n;
        endfunction

        function int tile_floor(int v);
            return (v < 0) ? -1 : (v >>> shift);
        endfunction

        function void fill(int lx, int rx, int ty, int by, bit set);
            int cols;
            int rows;
            cols = tiles_in(width, GRID_COLS);
            rows = tiles_in(height, GRID_ROWS);
            if (lx < 0) lx = 0;
            if (ty < 0) ty = 0;
            if (rx > cols - 1) rx = cols - 1;
            if (by > rows - 1) by = rows - 1;
            if (lx > rx || ty > by)
                return;
            for (int y = ty; y <= by; y++)
                for (int x = lx; x <= rx; x++)
                    dirty_rows[y][x] = set;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, int xf, int xl, int yf, int yl);
            int round;
            int tsize;
            int r;
            int b;
            int ex;
            int ey;
            int x;
            int run_lo;
            int found;
            run_rect_t rect;
            round = (1 << shift) - 1;
            tsize = round + 1;
            found = 0;
            case (cmd)
                CMD_DIRTY:
                begin
                    if (xf <= xl && yf <= yl)
                        fill(xf >>> shift, xl >>> shift, yf >>> shift, yl >>> shift, 1'b1);
                end
                CMD_CLEAN:
                begin
                    if (xf <= xl && yf <= yl)
                    begin
                        r = xl;
                        b = yl;
                        if (r >= width - 1) r = width + round;
                        if (b >= height - 1) b = height + round;
                        fill((xf + round) >>> shift, tile_floor(r - round),
                             (yf + round) >>> shift, tile_floor(b - round), 1'b0);
                    end
                end
                CMD_SCAN:
                begin
                    if (xf <= xl && yf <= yl)
                    begin
                        ex = xl >>> shift;
                        ey = yl >>> shift;
                        if (ex > tiles_in(width, GRID_COLS) - 1) ex = tiles_in(width, GRID_COLS) - 1;
                        if (ey > tiles_in(height, GRID_ROWS) - 1) ey = tiles_in(height, GRID_ROWS) - 1;
                        for (int y = yf >>> shift; y <= ey; y++)
                        begin
                            x = xf >>> shift;
                            while (x <= ex)
                            begin
                                if (!dirty_rows[y][x])
                                begin
                                    x++;
                                    continue;
                                end
                                run_lo = x;
                                while (x <= ex && dirty_rows[y][x])
                                    x++;
                                rect.rect_valid = 1'b1;
                                rect.last       = 1'b0;
                                rect.x_first    = XW'((run_lo * tsize < xf) ? xf : run_lo * tsize);
                                rect.x_last     = XW'((x * tsize - 1 > xl) ? xl : x * tsize - 1);
                                rect.y_first    = YW'((y * tsize < yf) ? yf : y * tsize);
                                rect.y_last     = YW'((y * tsize + round > yl) ? yl
                                                                               : y * tsize + round);
                                pending_rects.push_back(rect);
                                found++;
                            end
                        end
                    end
                    if (found == 0)
                    begin
                        rect = '0;
                        rect.last = 1'b1;
                        pending_rects.push_back(rect);
                    end
                    else
                        pending_rects[pending_rects.size() - 1].last = 1'b1;
                end
                default:
                    ;
            endcase
        endfunction

        function string show(run_rect_t r);
            return $sformatf("valid=%0d last=%0d x=%0d..%0d y=%0d..%0d", r.rect_valid, r.last,
                             r.x_first, r.x_last, r.y_first, r.y_last);
        endfunction

        task report(string msg);
            if (errors < 50)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_beat(run_rect_t got);
            run_rect_t want;
            if (pending_rects.size() == 0)
            begin
                report({"beat with nothing expected: ", show(got)});
                return;
            end
            want = pending_rects.pop_front();
            if (got !== want)
                report({"got ", show(got), ", want ", show(want)});
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   steady;
    int   items_sent;
    int   cycle_count;
    run_rect_board board;

    dtm_cfg_if cfg_bus ();
    dtm_req_if req_bus ();
    dtm_rsp_if rsp_bus ();

    dirty_tile_map_with_run_rects_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL dirty_tile_map_with_run_rects_top");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_bus.valid && cfg_bus.ready)
            board.apply_reg(cfg_bus.idx, cfg_bus.data);
    end

    always @(posedge clk)
    begin
        if (rst_n && req_bus.valid && req_bus.ready)
            board.note_command(req_bus.cmd, int'(req_bus.x_first), int'(req_bus.x_last),
                               int'(req_bus.y_first), int'(req_bus.y_last));
    end

    always @(posedge clk)
    begin : rsp_monitor
        run_rect_t beat;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            beat.rect_valid = rsp_bus.rect_valid;
            beat.last       = rsp_bus.last;
            beat.x_first    = rsp_bus.out_x_first;
            beat.x_last     = rsp_bus.out_x_last;
            beat.y_first    = rsp_bus.out_y_first;
            beat.y_last     = rsp_bus.out_y_last;
            board.check_beat(beat);
        end
    end

    initial
    begin : rsp_sink
        int stall;
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_bus.valid && rsp_bus.ready));
        end
    end

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int xf, input int xl,
                            input int yf, input int yl);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.cmd     <= cmd;
        req_bus.x_first <= xf[XW-1:0];
        req_bus.x_last  <= xl[XW-1:0];
        req_bus.y_first <= yf[YW-1:0];
        req_bus.y_last  <= yl[YW-1:0];
        do
            @(posedge clk);
        while (!(req_bus.valid && req_bus.ready));
        if (cmd != CMD_NONE)
            items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.idx   <= idx;
        cfg_bus.data  <= data[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!(cfg_bus.valid && cfg_bus.ready));
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Dirty and clean give no response, so an optional margin follows the last beat.
    task automatic wait_quiet(input bit with_margin);
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_rects.size() != 0)
            @(posedge clk);
        if (with_margin)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_grid(input int shift, input int width, input int height);
        write_reg(REG_PIXEL_WIDTH, width);
        write_reg(REG_PIXEL_HEIGHT, height);
        write_reg(REG_TILE_SHIFT, ($urandom & 32'hFF8) | shift);
    endtask

    function automatic void pick_span(input int reach, input int tile, input int maxv,
                                      output int lo, output int hi);
        int mode;
        int a;
        int b;
        int t;
        mode = $urandom_range(0, 99);
        if (mode < 8)
        begin
            lo = $urandom_range(0, maxv);
            hi = $urandom_range(0, maxv);
            return;
        end
        if (mode < 11)
        begin
            lo = 0;
            hi = maxv;
            return;
        end
        a = $urandom_range(0, reach - 1);
        b = $urandom_range(0, reach - 1);
        if (mode < 18)
        begin
            lo = a;
            hi = b;
            return;
        end
        if (a > b)
        begin
            t = a;
            a = b;
            b = t;
        end
        if (mode < 55)
        begin
            a = a / tile * tile;
            b = b / tile * tile + tile - 1;
            if (b > maxv) b = maxv;
        end
        lo = a;
        hi = b;
    endfunction

    task automatic run_batch(input int count);
        int goal;
        int pick;
        int tile;
        int xf;
        int xl;
        int yf;
        int yl;
        logic [CMD_W-1:0] cmd;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            tile = 1 << board.shift;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                cmd = CMD_DIRTY;
            else if (pick < 68)
                cmd = CMD_CLEAN;
            else if (pick < 95)
                cmd = CMD_SCAN;
            else
                cmd = CMD_NONE;
            pick_span(((GRID_COLS + 1) * tile > 2048) ? 2048 : (GRID_COLS + 1) * tile,
                      tile, 2047, xf, xl);
            pick_span(((GRID_ROWS + 1) * tile > 1024) ? 1024 : (GRID_ROWS + 1) * tile,
                      tile, 1023, yf, yl);
            send_cmd(cmd, xf, xl, yf, yl);
            if ($urandom_range(0, 39) == 0)
                wait_quiet(1'b0);
        end
    endtask

    function automatic int pick_extent(input int span, input int full, input int mask);
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 40)
            return $urandom_range(1, (span > full) ? full : span);
        if (mode < 70)
            return $urandom_range(1, full);
        if (mode < 85)
            return $urandom_range(0, 1) ? mask : 0;
        return $urandom & 32'hFFF;
    endfunction

    initial
    begin : stimulus
        int shift;
        board = new;
        board.reset_state();
        rst_n           <= 1'b0;
        steady          = 1'b0;
        items_sent      = 0;
        cycle_count     = 0;
        req_bus.valid   <= 1'b0;
        req_bus.cmd     <= CMD_DIRTY;
        req_bus.x_first <= '0;
        req_bus.x_last  <= '0;
        req_bus.y_first <= '0;
        req_bus.y_last  <= '0;
        cfg_bus.valid   <= 1'b0;
        cfg_bus.idx     <= REG_TILE_SHIFT;
        cfg_bus.data    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(CMD_SCAN, 0, 2047, 0, 1023);
        send_cmd(CMD_CLEAN, 0, 127, 0, 63);
        send_cmd(CMD_SCAN, 0, 2047, 0, 1023);
        send_cmd(CMD_DIRTY, 0, 0, 0, 0);
        send_cmd(CMD_DIRTY, 2047, 2047, 1023, 1023);
        send_cmd(CMD_DIRTY, 10, 5, 0, 63);
        send_cmd(CMD_DIRTY, 16, 23, 8, 15);
        send_cmd(CMD_DIRTY, 40, 55, 8, 8);
        send_cmd(CMD_CLEAN, 1, 127, 0, 63);
        send_cmd(CMD_SCAN, 4, 100, 4, 60);
        send_cmd(CMD_SCAN, 50, 40, 0, 63);
        send_cmd(CMD_NONE, 0, 2047, 0, 1023);
        send_cmd(CMD_SCAN, 200, 2047, 0, 1023);
        send_cmd(CMD_DIRTY, 0, 2047, 0, 1023);
        send_cmd(CMD_CLEAN, 8, 15, 0, 1023);
        send_cmd(CMD_CLEAN, 0, 2047, 1023, 1023);
        send_cmd(CMD_CLEAN, 3, 12, 2, 5);
        send_cmd(CMD_CLEAN, 64, 126, 0, 30);
        send_cmd(CMD_CLEAN, 96, 130, 40, 63);
        send_cmd(CMD_SCAN, 0, 2047, 0, 1023);
        send_cmd(CMD_SCAN, 0, 0, 0, 0);
        send_cmd(CMD_SCAN, 0, 2047, 1023, 1023);
        send_cmd(CMD_SCAN, 9, 9, 9, 9);

        wait_quiet(1'b1);
        set_grid(0, 1, 1);
        run_batch(15);
        wait_quiet(1'b1);
        set_grid(7, 2048, 1024);
        run_batch(15);
        wait_quiet(1'b1);
        set_grid(0, 16, 8);
        run_batch(15);
        wait_quiet(1'b1);
        set_grid(4, 0, 64);
        run_batch(15);
        wait_quiet(1'b1);
        set_grid(1, 4095, 2047);
        write_reg(REG_SPARE, 12'hFFF);
        run_batch(15);
        wait_quiet(1'b1);
        set_grid(7, 1, 1024);
        run_batch(15);

        while (items_sent < ITEM_TARGET)
        begin
            wait_quiet(1'b1);
            steady = ($urandom_range(0, 3) == 0);
            shift = $urandom_range(0, 7);
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_TILE_SHIFT, ($urandom & 32'hFF8) | shift);
            else if ($urandom_range(0, 1) == 0)
                set_grid(shift, pick_extent(GRID_COLS << shift, 2048, 4095),
                         pick_extent(GRID_ROWS << shift, 1024, 2047));
            else
            begin
                write_reg(REG_TILE_SHIFT, ($urandom & 32'hFF8) | shift);
                write_reg(REG_PIXEL_HEIGHT, pick_extent(GRID_ROWS << shift, 1024, 2047));
                write_reg(REG_PIXEL_WIDTH, pick_extent(GRID_COLS << shift, 2048, 4095));
            end
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_SPARE, $urandom);
            run_batch($urandom_range(15, 35));
        end

        wait_quiet(1'b1);
        if (board.errors == 0)
            $display("PASS dirty_tile_map_with_run_rects_top");
        else
            $display("FAIL dirty_tile_map_with_run_rects_top");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/dtm_pkg.sv
hw/rtl/dtm_ifs.sv
hw/rtl/dtm_front.sv
hw/rtl/dtm_queue.sv
hw/rtl/dtm_back.sv
hw/rtl/dirty_tile_map_with_run_rects_top.sv
tb/tb_dirty_tile_map_with_run_rects_top.sv
